### rtl/mwom_pkg.sv
// ----------------------------------------------------------------------------
// mwom_pkg
// Types, constants and the quarter-wave sine table for the oscillator mixer.
// ----------------------------------------------------------------------------
package mwom_pkg;

   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_INDEX_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int HEADROOM_VOICES  = 8;
   localparam int GAIN_SHIFT       = 29 + $clog2(HEADROOM_VOICES);

   localparam logic [15:0] VOL_MAX   = 16'h8000;
   localparam logic [15:0] VOL_RESET = 16'h4000;
   localparam logic [15:0] WAVE_FULL = 16'h8000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } wave_mode_type;

   typedef enum logic [1:0] {
      CSR_WAVE_MODE       = 2'd0,
      CSR_PHASE_INCREMENT = 2'd1,
      CSR_VOLUME          = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   typedef logic [15:0] sine_table_type [SINE_TABLE_DEPTH];

   // restoring shift-subtract quotient for the table constants
   function automatic longint unsigned udiv_shift(longint unsigned num,
                                                  longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // taylor series in q30, rounded to q1.15
   function automatic sine_table_type build_sine_table();
      sine_table_type  tbl;
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      longint unsigned rounded;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x    = (longint'(k) * HALF_PI_Q30) >> SINE_INDEX_BITS;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv_shift(term, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rounded = (longint'(sum) + 64'd16384) >> 15;
         tbl[k]  = rounded[15:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

### rtl/multi_waveform_oscillator_mixer.sv
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_mixer
// Phase-accumulator tone oscillator added to a stereo sample stream.
// ----------------------------------------------------------------------------
// One item per cycle unless stalled: the first register holds the
// samples with the wave value shaped from the current phase (sine table,
// square, triangle or sawtooth), the second holds the sums after one
// 16x16 gain multiply. The phase advances by the increment on each transfer.
// A stalled output holds the pipe only when the first stage is also full.
module multi_waveform_oscillator_mixer
   import mwom_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_left_in,
   input  logic signed [15:0] req_right_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out
);

   wave_mode_type      wave_mode_ff;
   logic [31:0]        phase_increment_ff;
   logic [15:0]        volume_ff;
   logic [31:0]        phase_ff;
   logic [31:0]        phase_in;

   logic               s1_valid_ff;
   logic signed [15:0] s1_left_ff;
   logic signed [15:0] s1_right_ff;
   logic [15:0]        s1_mag_ff;
   logic               s1_neg_ff;
   logic [15:0]        s1_vol_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_left_ff;
   logic signed [15:0] rsp_right_ff;

   logic               out_advance;
   logic               s1_advance;
   logic               req_accept;

   logic [29:0]        sine_frac;
   logic [31:0]        tri_dist;
   logic signed [32:0] tri_offset;
   logic [32:0]        tri_abs;
   logic [31:0]        saw_abs;
   logic [15:0]        mag_in;
   logic               neg_in;
   logic [15:0]        vol_in;

   logic [31:0]        prod;
   logic [46:0]        scaled;
   logic [15:0]        gain_mag;
   logic [15:0]        gain;
   logic signed [15:0] rsp_left_in;
   logic signed [15:0] rsp_right_in;

   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = !s1_valid_ff || out_advance;
   assign req_stall   = !s1_advance;
   assign req_accept  = req_valid && s1_advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   assign phase_in = phase_ff + phase_increment_ff;

   // wave shaping from the current phase
   always_comb begin
      sine_frac  = phase_ff[30] ? ~phase_ff[29:0] : phase_ff[29:0];
      tri_dist   = phase_ff[31] ? {1'b0, phase_ff[30:0]} : (32'h8000_0000 - phase_ff);
      tri_offset = $signed({1'b0, tri_dist}) - 33'sh0_4000_0000;
      tri_abs    = tri_offset[32] ? 33'(-tri_offset) : 33'(tri_offset);
      saw_abs    = phase_ff[31] ? (phase_ff - 32'h8000_0000) : (32'h8000_0000 - phase_ff);
      case (wave_mode_ff)
         WAVE_SINE: begin
            mag_in = SINE_TABLE[sine_frac[29 -: SINE_INDEX_BITS]];
            neg_in = phase_ff[31];
         end
         WAVE_SQUARE: begin
            mag_in = WAVE_FULL;
            neg_in = phase_ff > 32'h8000_0000;
         end
         WAVE_TRIANGLE: begin
            mag_in = tri_abs[30:15];
            neg_in = !tri_offset[32];
         end
         WAVE_SAWTOOTH: begin
            mag_in = saw_abs[31:16];
            neg_in = !phase_ff[31];
         end
         default: begin
            mag_in = '0;
            neg_in = 1'b0;
         end
      endcase
      vol_in = (volume_ff > VOL_MAX) ? VOL_MAX : volume_ff;
   end

   // gain: mag * vol * 32767 / (voices * 2^29)
   always_comb begin
      prod     = 32'(s1_mag_ff) * 32'(s1_vol_ff);
      scaled   = {prod, 15'b0} - {15'b0, prod};
      gain_mag = 16'(scaled[46:GAIN_SHIFT]);
      gain     = s1_neg_ff ? (16'd0 - gain_mag) : gain_mag;
      rsp_left_in  = s1_left_ff + $signed(gain);
      rsp_right_in = s1_right_ff + $signed(gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff       <= WAVE_SINE;
         phase_increment_ff <= '0;
         volume_ff          <= VOL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WAVE_MODE:       wave_mode_ff       <= wave_mode_type'(csr_write_data[1:0]);
            CSR_PHASE_INCREMENT: phase_increment_ff <= csr_write_data;
            CSR_VOLUME:          volume_ff          <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
         end
         if (s1_advance) begin
            s1_valid_ff <= req_valid;
         end
         if (out_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_left_ff  <= req_left_in;
         s1_right_ff <= req_right_in;
         s1_mag_ff   <= mag_in;
         s1_neg_ff   <= neg_in;
         s1_vol_ff   <= vol_in;
      end
      if (out_advance && s1_valid_ff) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !s1_valid_ff |-> !req_stall)
      else $error("input stalled with an empty first stage");

   assert property (@(posedge clock) disable iff (reset) req_accept |=> s1_valid_ff)
      else $error("transfer lost in first stage");

   assert property (@(posedge clock) disable iff (reset) !req_accept |=> $stable(phase_ff))
      else $error("phase moved without a transfer");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_advance) |=> rsp_valid_ff)
      else $error("result lost between stages");

endmodule
